// ----- sv/amg_pkg.sv -----
// Shared types, codes and default sizes for the adjacency matrix graph store.
package amg_pkg;

    // Default sizes: vertex, key and weight sizes feed the top level parameters, queue depth the front end.
    localparam int AMG_MAX_VERTICES = 16;
    localparam int AMG_KEY_WIDTH    = 32;
    localparam int AMG_WEIGHT_WIDTH = 32;
    localparam int AMG_QUEUE_DEPTH  = 2;

    // Function codes carried by an input beat.
    localparam logic [3:0] FN_ADD_VERTEX   = 4'd0;
    localparam logic [3:0] FN_ADD_EDGE     = 4'd1;
    localparam logic [3:0] FN_ERASE_EDGE   = 4'd2;
    localparam logic [3:0] FN_ERASE_VERTEX = 4'd3;
    localparam logic [3:0] FN_NEIGHBORS    = 4'd4;
    localparam logic [3:0] FN_VISIT        = 4'd5;
    localparam logic [3:0] FN_IS_VISITED   = 4'd6;
    localparam logic [3:0] FN_CLEAR_VISITS = 4'd7;
    localparam logic [3:0] FN_COST         = 4'd8;
    localparam logic [3:0] FN_KEY_AT       = 4'd9;
    localparam logic [3:0] FN_COST_ROW     = 4'd10;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_RANGE     = 3'd4
    } t_status;

    // Decoded operation handed from the front end to the back end.
    typedef enum logic [3:0] {
        OP_ADD_V,
        OP_ADD_E,
        OP_ERASE_E,
        OP_ERASE_V,
        OP_NEIGH,
        OP_VISIT,
        OP_IS_VIS,
        OP_CLR_VIS,
        OP_COST,
        OP_KEY_AT,
        OP_COST_ROW,
        OP_BAD
    } t_op;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_RESOLVE,
        S_WR2,
        S_EMIT,
        S_ONEOUT,
        S_ROWRD,
        S_ROWOUT,
        S_KMRD,
        S_KMWR,
        S_MMRD,
        S_MMWR,
        S_SHRINK
    } t_state;

    // Input beat.
    typedef struct packed {
        logic [3:0]         func;
        logic [31:0]        key_a;
        logic [31:0]        key_b;
        logic signed [31:0] weight;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
    } t_in;

    // Result beat.
    typedef struct packed {
        t_status            status;
        logic [31:0]        key_out;
        logic signed [31:0] cost;
        logic               edge_present;
        logic               visited_flag;
        logic [4:0]         vertex_count;
        logic               last;
    } t_out;

    // Classified command waiting in the queue.
    typedef struct packed {
        t_op                op;
        logic [31:0]        key_a;
        logic [31:0]        key_b;
        logic signed [31:0] weight;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
    } t_cmd;

endpackage

// ----- sv/amg_front.sv -----
// Front end: decodes input beats and queues them for the back end.
module amg_front import amg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    localparam int QPW  = (AMG_QUEUE_DEPTH > 1) ? $clog2(AMG_QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(AMG_QUEUE_DEPTH + 1);

    t_cmd            r_q [AMG_QUEUE_DEPTH];
    logic [QPW-1:0]  r_wp;
    logic [QPW-1:0]  r_rp;
    logic [CNTW-1:0] r_cnt;
    t_cmd            c_cmd;
    logic            c_push;
    logic            c_pop;

    // Classify the function code.
    always_comb begin
        c_cmd.key_a     = i_in.key_a;
        c_cmd.key_b     = i_in.key_b;
        c_cmd.weight    = i_in.weight;
        c_cmd.row_index = i_in.row_index;
        c_cmd.col_index = i_in.col_index;
        unique case (i_in.func)
            FN_ADD_VERTEX:   c_cmd.op = OP_ADD_V;
            FN_ADD_EDGE:     c_cmd.op = OP_ADD_E;
            FN_ERASE_EDGE:   c_cmd.op = OP_ERASE_E;
            FN_ERASE_VERTEX: c_cmd.op = OP_ERASE_V;
            FN_NEIGHBORS:    c_cmd.op = OP_NEIGH;
            FN_VISIT:        c_cmd.op = OP_VISIT;
            FN_IS_VISITED:   c_cmd.op = OP_IS_VIS;
            FN_CLEAR_VISITS: c_cmd.op = OP_CLR_VIS;
            FN_COST:         c_cmd.op = OP_COST;
            FN_KEY_AT:       c_cmd.op = OP_KEY_AT;
            FN_COST_ROW:     c_cmd.op = OP_COST_ROW;
            default:         c_cmd.op = OP_BAD;
        endcase
    end

    // Queue handshake.
    assign o_in_stall  = (r_cnt == CNTW'(AMG_QUEUE_DEPTH));
    assign c_push      = i_in_valid && !o_in_stall;
    assign c_pop       = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (c_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (c_push && !c_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (c_pop && !c_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/amg_back.sv -----
// Back end: executes graph commands against the key, edge and mark stores.
module amg_back import amg_pkg::*; #(
    parameter int MAX_VERTICES = AMG_MAX_VERTICES,
    parameter int KEY_WIDTH    = AMG_KEY_WIDTH,
    parameter int WEIGHT_WIDTH = AMG_WEIGHT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall
);

    localparam int VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int AW     = 2 * VW;
    localparam int WDEPTH = 1 << AW;

    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic [CW-1:0]             r_total;
    logic [CW-1:0]             r_idx;
    logic                      r_pv;
    logic [VW-1:0]             r_pidx;
    logic [VW-1:0]             r_fa;
    logic [VW-1:0]             r_fb;
    logic                      r_ha;
    logic                      r_hb;
    logic [VW-1:0]             r_row;
    logic [VW-1:0]             r_col;
    t_status                   r_status;
    logic                      r_visf;
    logic [MAX_VERTICES-1:0]   r_vis;
    logic [MAX_VERTICES-1:0]   r_ev [MAX_VERTICES];
    logic [KEY_WIDTH-1:0]      r_key_mem [MAX_VERTICES];
    logic [KEY_WIDTH-1:0]      r_key_rd;
    logic signed [WEIGHT_WIDTH-1:0] r_w_mem [WDEPTH];
    logic signed [WEIGHT_WIDTH-1:0] r_w_rd;
    logic                      r_out_v;
    t_out                      r_out;

    logic                      c_out_free;
    logic [VW-1:0]             c_ri;
    logic [VW-1:0]             c_ci;
    logic                      c_ri_bad;
    logic                      c_ci_bad;
    logic [KEY_WIDTH-1:0]      c_ka;
    logic [KEY_WIDTH-1:0]      c_kb;
    logic signed [WEIGHT_WIDTH-1:0] c_w;
    logic [CW-1:0]             c_nm1;
    logic [CW-1:0]             c_nm2;
    logic [CW-1:0]             c_idx_inc;
    logic [VW-1:0]             c_col_idx;
    logic [MAX_VERTICES-1:0]   c_row;
    logic                      c_any;
    logic                      c_more;
    logic                      c_pres;
    logic                      c_skip;
    logic                      c_row_last;
    logic                      c_found;
    logic [VW-1:0]             c_sr;
    logic [VW-1:0]             c_sc;
    logic [MAX_VERTICES-1:0]   c_ev [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]   c_vis;
    logic [VW-1:0]             c_key_ra;
    logic                      c_key_we;
    logic [VW-1:0]             c_key_wa;
    logic [KEY_WIDTH-1:0]      c_key_wd;
    logic [AW-1:0]             c_w_ra;
    logic                      c_w_we;
    logic [AW-1:0]             c_w_wa;
    logic signed [WEIGHT_WIDTH-1:0] c_w_wd;
    logic                      c_emit;
    t_out                      c_e;

    // Common decoded values.
    assign c_out_free = !r_out_v || !i_out_stall;
    assign c_ri       = VW'(r_cmd.row_index);
    assign c_ci       = VW'(r_cmd.col_index);
    assign c_ri_bad   = (r_cmd.row_index >= r_total);
    assign c_ci_bad   = (r_cmd.col_index >= r_total);
    assign c_ka       = KEY_WIDTH'(r_cmd.key_a);
    assign c_kb       = KEY_WIDTH'(r_cmd.key_b);
    assign c_w        = WEIGHT_WIDTH'(r_cmd.weight);
    assign c_nm1      = r_total - 1'b1;
    assign c_nm2      = r_total - CW'(2);
    assign c_idx_inc  = r_idx + 1'b1;
    assign c_col_idx  = r_idx[VW-1:0];
    assign c_row      = r_ev[r_fa];
    assign c_pres     = c_row[c_col_idx];
    assign c_skip     = (r_cmd.op == OP_NEIGH) && !c_pres;
    assign c_found    = ((r_cmd.op == OP_ADD_E) || (r_cmd.op == OP_ERASE_E)) ?
                        (r_ha && r_hb) : r_ha;
    assign c_sr       = (r_row < r_fa) ? r_row : VW'(r_row + 1'b1);
    assign c_sc       = (r_col < r_fa) ? r_col : VW'(r_col + 1'b1);

    // Scan the source row for present edges, overall and past the column.
    always_comb begin
        c_any  = 1'b0;
        c_more = 1'b0;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (c_row[j] && (j < int'(r_total))) begin
                c_any = 1'b1;
                if (j > int'(r_idx)) begin
                    c_more = 1'b1;
                end
            end
        end
    end

    assign c_row_last = (r_cmd.op == OP_NEIGH) ? !c_more : (c_idx_inc == r_total);

    // Compacted present bits and marks for a vertex erase.
    always_comb begin
        int sr;
        int sc;
        for (int r = 0; r < MAX_VERTICES; r++) begin
            sr = (r < int'(r_fa)) ? r : r + 1;
            if (sr > MAX_VERTICES - 1) begin
                sr = MAX_VERTICES - 1;
            end
            c_vis[r] = (r < int'(c_nm1)) ? r_vis[sr] : 1'b0;
            for (int c = 0; c < MAX_VERTICES; c++) begin
                sc = (c < int'(r_fa)) ? c : c + 1;
                if (sc > MAX_VERTICES - 1) begin
                    sc = MAX_VERTICES - 1;
                end
                c_ev[r][c] = (r < int'(c_nm1) && c < int'(c_nm1)) ? r_ev[sr][sc] : 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_cmd.op)
                    OP_ADD_E, OP_ERASE_E, OP_ERASE_V, OP_NEIGH, OP_VISIT,
                    OP_COST_ROW: n_state = (r_total == '0) ? S_EMIT : S_SEARCH;
                    OP_IS_VIS:   n_state = S_SEARCH;
                    OP_COST:     n_state = (c_ri_bad || c_ci_bad) ? S_EMIT : S_ONEOUT;
                    OP_KEY_AT:   n_state = c_ri_bad ? S_EMIT : S_ONEOUT;
                    default:     n_state = S_EMIT;
                endcase
            end
            S_SEARCH: begin
                if ((r_idx >= r_total) && !r_pv) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (!c_found) begin
                    n_state = S_EMIT;
                end else begin
                    unique case (r_cmd.op)
                        OP_ADD_E:    n_state = S_WR2;
                        OP_ERASE_V:  n_state = S_KMRD;
                        OP_NEIGH:    n_state = c_any ? S_ROWRD : S_EMIT;
                        OP_COST_ROW: n_state = S_ROWRD;
                        default:     n_state = S_EMIT;
                    endcase
                end
            end
            S_WR2: n_state = S_EMIT;
            S_EMIT, S_ONEOUT: begin
                if (c_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ROWRD: n_state = S_ROWOUT;
            S_ROWOUT: begin
                if (c_skip) begin
                    n_state = (c_idx_inc >= r_total) ? S_IDLE : S_ROWRD;
                end else if (c_out_free) begin
                    n_state = c_row_last ? S_IDLE : S_ROWRD;
                end
            end
            S_KMRD: begin
                if (c_idx_inc >= r_total) begin
                    n_state = (r_total > CW'(1)) ? S_MMRD : S_SHRINK;
                end else begin
                    n_state = S_KMWR;
                end
            end
            S_KMWR: n_state = S_KMRD;
            S_MMRD: n_state = S_MMWR;
            S_MMWR: begin
                if ((CW'(r_col) == c_nm2) && (CW'(r_row) == c_nm2)) begin
                    n_state = S_SHRINK;
                end else begin
                    n_state = S_MMRD;
                end
            end
            S_SHRINK: n_state = S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports, queue pop and result beat.
    always_comb begin
        o_cmd_pop = 1'b0;
        c_key_ra  = '0;
        c_key_we  = 1'b0;
        c_key_wa  = '0;
        c_key_wd  = c_ka;
        c_w_ra    = '0;
        c_w_we    = 1'b0;
        c_w_wa    = '0;
        c_w_wd    = c_w;
        c_emit    = 1'b0;
        c_e       = '0;
        c_e.vertex_count = 5'(r_total);
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            S_DISPATCH, S_ONEOUT: begin
                c_key_ra = (r_cmd.op == OP_COST) ? c_ci : c_ri;
                c_w_ra   = {c_ri, c_ci};
                if (r_state == S_DISPATCH) begin
                    if ((r_cmd.op == OP_ADD_V) && (r_total < CW'(MAX_VERTICES))) begin
                        c_key_we = 1'b1;
                        c_key_wa = r_total[VW-1:0];
                    end
                end else begin
                    c_emit      = c_out_free;
                    c_e.status  = STAT_OK;
                    c_e.key_out = 32'(r_key_rd);
                    c_e.last    = 1'b1;
                    if (r_cmd.op == OP_COST) begin
                        c_e.edge_present = r_ev[c_ri][c_ci];
                        c_e.cost         = r_ev[c_ri][c_ci] ? 32'(r_w_rd) : '0;
                    end
                end
            end
            S_SEARCH: begin
                c_key_ra = r_idx[VW-1:0];
            end
            S_RESOLVE: begin
                if (c_found && (r_cmd.op == OP_ADD_E)) begin
                    c_w_we = 1'b1;
                    c_w_wa = {r_fa, r_fb};
                end
            end
            S_WR2: begin
                c_w_we = 1'b1;
                c_w_wa = {r_fb, r_fa};
            end
            S_EMIT: begin
                c_emit           = c_out_free;
                c_e.status       = r_status;
                c_e.visited_flag = r_visf;
                c_e.last         = 1'b1;
            end
            S_ROWRD, S_ROWOUT: begin
                c_key_ra = c_col_idx;
                c_w_ra   = {r_fa, c_col_idx};
                if (r_state == S_ROWOUT) begin
                    c_emit           = c_out_free && !c_skip;
                    c_e.status       = STAT_OK;
                    c_e.key_out      = 32'(r_key_rd);
                    c_e.edge_present = c_pres;
                    c_e.cost         = c_pres ? 32'(r_w_rd) : '0;
                    c_e.last         = c_row_last;
                end
            end
            S_KMRD: begin
                c_key_ra = VW'(c_idx_inc);
            end
            S_KMWR: begin
                c_key_we = 1'b1;
                c_key_wa = r_idx[VW-1:0];
                c_key_wd = r_key_rd;
            end
            S_MMRD: begin
                c_w_ra = {c_sr, c_sc};
            end
            S_MMWR: begin
                c_w_we = 1'b1;
                c_w_wa = {r_row, r_col};
                c_w_wd = r_w_rd;
            end
            default: begin
                c_emit = 1'b0;
            end
        endcase
    end

    // Key store with registered read.
    always_ff @(posedge i_clk) begin
        if (c_key_we) begin
            r_key_mem[c_key_wa] <= c_key_wd;
        end
        r_key_rd <= r_key_mem[c_key_ra];
    end

    // Weight store with registered read.
    always_ff @(posedge i_clk) begin
        if (c_w_we) begin
            r_w_mem[c_w_wa] <= c_w_wd;
        end
        r_w_rd <= r_w_mem[c_w_ra];
    end

    // Result register: loads a new beat once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (c_emit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out <= c_e;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // Sequencer state, vertex count, marks and present bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_pv    <= 1'b0;
            r_vis   <= '0;
            for (int r = 0; r < MAX_VERTICES; r++) begin
                r_ev[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                    end
                end
                S_DISPATCH: begin
                    r_idx  <= '0;
                    r_pv   <= 1'b0;
                    r_ha   <= 1'b0;
                    r_hb   <= 1'b0;
                    r_visf <= 1'b0;
                    unique case (r_cmd.op)
                        OP_ADD_V: begin
                            if (r_total >= CW'(MAX_VERTICES)) begin
                                r_status <= STAT_FULL;
                            end else begin
                                r_status                <= STAT_OK;
                                r_vis[r_total[VW-1:0]]  <= 1'b0;
                                r_total                 <= r_total + 1'b1;
                            end
                        end
                        OP_CLR_VIS: begin
                            r_status <= STAT_OK;
                            r_vis    <= '0;
                        end
                        OP_BAD, OP_COST, OP_KEY_AT: r_status <= STAT_RANGE;
                        OP_COST_ROW, OP_IS_VIS:     r_status <= STAT_NOT_FOUND;
                        default:                    r_status <= STAT_EMPTY;
                    endcase
                end
                S_SEARCH: begin
                    if (r_idx < r_total) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[VW-1:0];
                        r_idx  <= c_idx_inc;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (!r_ha && (r_key_rd == c_ka)) begin
                            r_ha <= 1'b1;
                            r_fa <= r_pidx;
                        end
                        if (!r_hb && (r_key_rd == c_kb)) begin
                            r_hb <= 1'b1;
                            r_fb <= r_pidx;
                        end
                    end
                end
                S_RESOLVE: begin
                    r_status <= c_found ? STAT_OK : STAT_NOT_FOUND;
                    if (c_found) begin
                        unique case (r_cmd.op)
                            OP_ADD_E: begin
                                r_ev[r_fa][r_fb] <= 1'b1;
                                r_ev[r_fb][r_fa] <= 1'b1;
                            end
                            OP_ERASE_E: r_ev[r_fa][r_fb] <= 1'b0;
                            OP_VISIT: begin
                                r_vis[r_fa] <= 1'b1;
                                r_visf      <= 1'b1;
                            end
                            OP_IS_VIS: r_visf <= r_vis[r_fa];
                            OP_ERASE_V: begin
                                r_ev  <= c_ev;
                                r_vis <= c_vis;
                                r_idx <= CW'(r_fa);
                                r_row <= '0;
                                r_col <= '0;
                            end
                            default: r_idx <= '0;
                        endcase
                    end
                end
                S_ROWOUT: begin
                    if (c_skip || c_out_free) begin
                        r_idx <= c_idx_inc;
                    end
                end
                S_KMWR: r_idx <= c_idx_inc;
                S_MMWR: begin
                    if (CW'(r_col) == c_nm2) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_SHRINK: r_total <= c_nm1;
                default: r_pv <= r_pv;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The vertex count never passes the capacity.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    // No beat is loaded while the held result is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall) |-> !c_emit)
        else $error("result overwritten while stalled");

    // A vertex erase lowers the count by exactly one.
    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHRINK) |=> (r_total == $past(r_total) - 1'b1))
        else $error("erase did not lower the count by one");

    // A found source vertex lies inside the vertex range.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE && r_ha) |-> (CW'(r_fa) < r_total))
        else $error("search hit outside vertex range");
`endif

endmodule

// ----- sv/adjacency_matrix_graph_store.sv -----
// Top level: bounded weighted graph store with a decode queue and an executing back end.
// Neighbor lists give one beat per present neighbor and cost row lists one beat per column;
// each is read from the key and weight stores first and holds while the result is stalled.
// Vertex erase, after the search, moves the keys down, compacts the weight matrix and then
// lowers the vertex count by one.
// The back end runs one command at a time; up to two more wait in the queue.
// Reset clears the vertex count, visited marks and edge present bits.
module adjacency_matrix_graph_store import amg_pkg::*; #(
    parameter int MAX_VERTICES = AMG_MAX_VERTICES,
    parameter int KEY_WIDTH    = AMG_KEY_WIDTH,
    parameter int WEIGHT_WIDTH = AMG_WEIGHT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic c_cmd_valid;
    t_cmd c_cmd;
    logic c_cmd_pop;

    // Decode and queue incoming beats.
    amg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (c_cmd_valid),
        .o_cmd       (c_cmd),
        .i_cmd_pop   (c_cmd_pop)
    );

    // Execute commands and produce result beats.
    amg_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .KEY_WIDTH    (KEY_WIDTH),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (c_cmd_valid),
        .i_cmd       (c_cmd),
        .o_cmd_pop   (c_cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
